// ===== design/pde_pkg.sv =====
// Shared types and constants for the playout delay estimator.
`default_nettype none

package pde_pkg;

    // Field widths
    localparam int SKEW_W  = 32;
    localparam int DELAY_W = 32;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = SKEW_W + FRAC_W;   // smoothed delay, unsigned 32.16

    // Default window depth of the skew ring
    localparam int WINDOW_DEPTH_DEF = 256;

    // Entries in the queue between front and back end (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Action codes on the input channel
    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    // Smoothing: delay = (max + 124 * delay) / 125
    localparam int WEIGHT_OLD = 124;
    localparam int DIVISOR    = 125;
    localparam int REM_W      = 7;              // remainder always below 125
    localparam int DIVIDEND_W = ACC_W + 8;      // (max << 16) + 124 * delay

    // Divide by 125 a 14-bit digit per step; each partial dividend is below
    // 125 * 2^14 < 2^21, where the reciprocal product below is exact
    localparam int DIGIT_W     = 14;
    localparam int DIV_STEPS   = DIVIDEND_W / DIGIT_W;
    localparam int RECIP_MUL   = 2147484;       // ceil(2^28 / 125)
    localparam int RECIP_SHIFT = 28;

    // Classified item handed from front to back end
    typedef struct packed {
        logic              tick;
        logic [SKEW_W-1:0] skew;
    } item_t;

endpackage

`default_nettype wire

// ===== design/pde_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none

module pde_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic                        action,
    input  wire logic [pde_pkg::SKEW_W-1:0]  skew_sample,
    output logic                             q_valid,
    output pde_pkg::item_t                   q_item,
    input  wire logic                        q_pop
);

    localparam int QA = $clog2(pde_pkg::QUEUE_DEPTH);
    localparam int QC = $clog2(pde_pkg::QUEUE_DEPTH + 1);

    pde_pkg::item_t queue_reg [pde_pkg::QUEUE_DEPTH];
    logic [QA-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QA-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC-1:0]  count_reg, count_next;
    logic           push;
    pde_pkg::item_t push_item;

    // Classify the incoming transaction
    always_comb
    begin
        push_item.tick = (action == pde_pkg::ACTION_TICK);
        push_item.skew = skew_sample;
    end

    assign item_ready = (count_reg != QC'(pde_pkg::QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign q_item     = queue_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA'(pde_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA'(pde_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Checks
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC'(pde_pkg::QUEUE_DEPTH))
        else $error("queue fill level out of range");

    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill level lost a push");

endmodule

`default_nettype wire

// ===== design/pde_back.sv =====
// Back end: skew ring, window maximum scan, smoothing and the result register.
`default_nettype none

module pde_back #(
    parameter int WINDOW_DEPTH = pde_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  wire pde_pkg::item_t              q_item,
    output logic                             q_pop,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [pde_pkg::DELAY_W-1:0]      delay_ns
);

    localparam int AW       = $clog2(WINDOW_DEPTH);
    localparam int CW       = $clog2(WINDOW_DEPTH + 1);
    localparam int DW       = pde_pkg::DIVIDEND_W;
    localparam int SW       = pde_pkg::SKEW_W;
    localparam int AccW     = pde_pkg::ACC_W;
    localparam int RW       = pde_pkg::REM_W;
    localparam int StepW    = $clog2(pde_pkg::DIV_STEPS);
    localparam int ProdW    = AccW + 7;
    localparam int DigW     = pde_pkg::DIGIT_W;
    localparam int PartW    = RW + DigW;
    localparam int RecProdW = pde_pkg::RECIP_SHIFT + DigW;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_ADD    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [SW-1:0]                ring_mem [WINDOW_DEPTH];
    logic [SW-1:0]                rd_data_reg;
    logic [AW-1:0]                wr_idx_reg, wr_idx_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                scan_idx_reg, scan_idx_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [SW-1:0]                max_reg, max_next;
    logic [AccW-1:0]              delay_reg, delay_next;
    logic [ProdW-1:0]             prod_reg, prod_next;
    logic [DW-1:0]                div_reg, div_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [StepW-1:0]             step_reg, step_next;
    logic                         res_vld_reg, res_vld_next;
    logic [pde_pkg::DELAY_W-1:0]  res_reg, res_next;
    logic                         wr_en;
    logic                         issue;
    logic                         last_step;
    logic [PartW-1:0]             part;
    logic [RecProdW-1:0]          recip_prod;
    logic [DigW-1:0]              q_digit;
    logic [PartW-1:0]             q_back;
    logic [DW-1:0]                quot;

    assign q_pop         = q_valid && (state_reg == ST_IDLE);
    assign wr_en         = q_pop && !q_item.tick;
    assign issue         = (scan_idx_reg != count_reg);
    assign result_valid  = res_vld_reg;
    assign delay_ns      = res_reg;

    // One digit of the divide by 125: reciprocal multiply, then remainder
    assign part       = {rem_reg, div_reg[DW-1 -: DigW]};
    assign recip_prod = RecProdW'(part) * RecProdW'(pde_pkg::RECIP_MUL);
    assign q_digit    = recip_prod[pde_pkg::RECIP_SHIFT +: DigW];
    assign q_back     = PartW'(q_digit) * PartW'(pde_pkg::DIVISOR);
    assign quot       = {div_reg[DW-DigW-1:0], q_digit};
    assign last_step  = (step_reg == StepW'(pde_pkg::DIV_STEPS - 1));

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        wr_idx_next   = wr_idx_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = 1'b0;
        max_next      = max_reg;
        delay_next    = delay_reg;
        prod_next     = prod_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        res_vld_next  = res_vld_reg && !result_ready;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wr_en)
                begin
                    wr_idx_next = (wr_idx_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
                    if (count_reg != CW'(WINDOW_DEPTH))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (q_pop)
                begin
                    scan_idx_next = '0;
                    max_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Read address leads the compare: read data is compared in the cycle after its address
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                rd_vld_next = issue;
                if (rd_vld_reg && (rd_data_reg > max_reg))
                begin
                    max_next = rd_data_reg;
                end
                if (!issue && !rd_vld_reg)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // 124 * delay as (delay << 7) - (delay << 2)
                prod_next  = {delay_reg, 7'b0} - {5'b0, delay_reg, 2'b0};
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                div_next   = {1'b0, prod_reg} + {8'b0, max_reg, {pde_pkg::FRAC_W{1'b0}}};
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = RW'(part - q_back);
                div_next  = quot;
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    delay_next = quot[AccW-1:0];
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!res_vld_reg || result_ready)
                begin
                    res_vld_next = 1'b1;
                    res_next     = delay_reg[AccW-1:pde_pkg::FRAC_W];
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wr_idx_reg   <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            delay_reg    <= '0;
            step_reg     <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_idx_reg   <= wr_idx_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            delay_reg    <= delay_next;
            step_reg     <= step_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        max_reg  <= max_next;
        prod_reg <= prod_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    // Skew ring: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_idx_reg] <= q_item.skew;
        end
        rd_data_reg <= ring_mem[scan_idx_reg[AW-1:0]];
    end

    // Checks
    a_fill_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CW'(WINDOW_DEPTH)) |-> (CW'(wr_idx_reg) == count_reg))
        else $error("write index and sample count disagree before wrap");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= count_reg))
        else $error("scan ran past the stored samples");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < RW'(pde_pkg::DIVISOR)))
        else $error("division remainder out of range");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && last_step) |-> (quot[DW-1:AccW] == '0))
        else $error("smoothed delay overflowed 48 bits");

endmodule

`default_nettype wire

// ===== design/playout_delay_estimator_unit.sv =====
// Top level of the playout delay estimator.
`default_nettype none

// A sample transaction (action 0) is queued and then written into the skew ring, so
// samples sustain one per cycle while the back end is idle. A tick transaction
// (action 1) scans the stored samples through the ring's single registered read port,
// one entry per cycle, then forms (max << 16) + 124 * delay and divides it by 125 in
// four steps of one 14-bit digit each, by reciprocal multiplication: a tick occupies
// the back end for the scan of the N stored samples (N at most WINDOW_DEPTH) and the
// divide, and also while the previous delay still waits in the result register.
// A four-entry queue in front keeps accepting transactions while the back end works,
// until it is full, and the result register holds one finished delay until it is taken.

module playout_delay_estimator_unit #(
    parameter int WINDOW_DEPTH = pde_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic                        action,
    input  wire logic [pde_pkg::SKEW_W-1:0]  skew_sample,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [pde_pkg::DELAY_W-1:0]      delay_ns
);

    logic           q_valid;
    logic           q_pop;
    pde_pkg::item_t q_item;

    // Accept and queue
    pde_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .skew_sample (skew_sample),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // Store, scan and smooth
    pde_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .delay_ns      (delay_ns)
    );

endmodule

`default_nettype wire
